FILE: src/gb3s_pkg.sv
// Shared constants, word types and step codes for the 3x3 Gaussian blur stream unit.
`timescale 1ns / 1ps
`default_nettype none

package gb3s_pkg;

    // Frame limits and channel count.
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int CHANNELS    = 3;

    // Sample and pixel widths. A pixel holds red in the low byte, then green, then blue.
    localparam int SAMPLE_W    = 8;
    localparam int NUM_SAMPLES = 3;
    localparam int PIXEL_W     = NUM_SAMPLES * SAMPLE_W;
    localparam int SUM_W       = SAMPLE_W + 4;

    // Frame position counters and clamped dimensions.
    localparam int DIM_W       = 12;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WIDTH_W     = COL_W + 1;
    localparam int HEIGHT_W    = ROW_W + 1;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     RESET_WIDTH      = DIM_W'(1920);
    localparam logic [DIM_W-1:0]     RESET_HEIGHT     = DIM_W'(1080);

    // Input command codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] red_in;
        logic [SAMPLE_W-1:0] green_in;
        logic [SAMPLE_W-1:0] blue_in;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_out;
        logic [SAMPLE_W-1:0] green_out;
        logic [SAMPLE_W-1:0] blue_out;
        logic                end_of_row;
        logic                end_of_frame;
        logic                last_of_step;
    } out_word_t;

    // What an accepted word does once its line store data is back.
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_FILL,
        STEP_PUSH,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        logic [COL_W-1:0] col;
        logic             has_left;
        logic             wide_left;
        logic             row_end;
        pixel_t           pix;
    } step_t;

endpackage

`default_nettype wire

FILE: src/gb3s_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gb3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/gb3s_seq.sv
// Frame sequencer: configuration, raster position counters and the step register.
`timescale 1ns / 1ps
`default_nettype none

module gb3s_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gb3s_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gb3s_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    input  gb3s_pkg::in_word_t                 in_word,
    input  logic                               advance,
    output logic                               in_stall,
    output logic                               rd_en,
    output logic [gb3s_pkg::COL_W-1:0]         rd_addr,
    output logic                               b_valid,
    output gb3s_pkg::step_t                    b_step
);

    function automatic logic [gb3s_pkg::WIDTH_W-1:0] clamp_width(
        input logic [gb3s_pkg::DIM_W-1:0] value);
        logic [gb3s_pkg::WIDTH_W-1:0] result;
        if (value == '0)
            result = gb3s_pkg::WIDTH_W'(1);
        else if (32'(value) > 32'(gb3s_pkg::MAX_WIDTH))
            result = gb3s_pkg::WIDTH_W'(gb3s_pkg::MAX_WIDTH);
        else
            result = gb3s_pkg::WIDTH_W'(value);
        return result;
    endfunction

    function automatic logic [gb3s_pkg::HEIGHT_W-1:0] clamp_height(
        input logic [gb3s_pkg::DIM_W-1:0] value);
        logic [gb3s_pkg::HEIGHT_W-1:0] result;
        if (value == '0)
            result = gb3s_pkg::HEIGHT_W'(1);
        else if (32'(value) > 32'(gb3s_pkg::MAX_HEIGHT))
            result = gb3s_pkg::HEIGHT_W'(gb3s_pkg::MAX_HEIGHT);
        else
            result = gb3s_pkg::HEIGHT_W'(value);
        return result;
    endfunction

    logic [gb3s_pkg::WIDTH_W-1:0]  width_reg;
    logic [gb3s_pkg::HEIGHT_W-1:0] height_reg;
    logic [gb3s_pkg::COL_W-1:0]    col_reg, col_next;
    logic [gb3s_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [gb3s_pkg::COL_W-1:0]    drain_reg, drain_next;
    logic                          done_reg, done_next;
    logic                          b_valid_reg, b_valid_next;
    gb3s_pkg::step_t               step_reg, step_next;

    logic                          accept;
    logic                          is_pixel;
    logic [gb3s_pkg::COL_W-1:0]    col_cur;
    logic [gb3s_pkg::ROW_W-1:0]    row_cur;
    logic [gb3s_pkg::COL_W-1:0]    pos;
    logic [gb3s_pkg::COL_W-1:0]    x;
    logic                          row_end;
    logic                          last_row;
    gb3s_pkg::step_kind_t          kind;

    assign in_stall = b_valid_reg & ~advance;
    assign accept   = in_valid & ~in_stall;
    assign is_pixel = (in_word.cmd == gb3s_pkg::CMD_PIXEL);

    // A pixel arriving after a complete frame starts the next frame at the origin.
    always_comb
    begin
        col_cur  = done_reg ? '0 : col_reg;
        row_cur  = done_reg ? '0 : row_reg;
        pos      = is_pixel ? col_cur : drain_reg;
        x        = ({1'b0, pos} >= width_reg) ?
                   gb3s_pkg::COL_W'(width_reg - gb3s_pkg::WIDTH_W'(1)) : pos;
        row_end  = ({1'b0, x} + gb3s_pkg::WIDTH_W'(1)) >= width_reg;
        last_row = ({1'b0, row_cur} + gb3s_pkg::HEIGHT_W'(1)) >= height_reg;
        if (is_pixel)
            kind = (row_cur == '0) ? gb3s_pkg::STEP_FILL : gb3s_pkg::STEP_PUSH;
        else
            kind = done_reg ? gb3s_pkg::STEP_DRAIN : gb3s_pkg::STEP_NONE;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        done_next  = done_reg;
        if (cfg_write)
        begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
            done_next  = 1'b0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                drain_next = '0;
                done_next  = 1'b0;
                row_next   = row_cur;
                if (row_end)
                begin
                    col_next = '0;
                    if (last_row)
                        done_next = 1'b1;
                    else
                        row_next = row_cur + gb3s_pkg::ROW_W'(1);
                end
                else
                begin
                    col_next = x + gb3s_pkg::COL_W'(1);
                end
            end
            else if (done_reg)
            begin
                if (row_end)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    drain_next = '0;
                    done_next  = 1'b0;
                end
                else
                begin
                    drain_next = x + gb3s_pkg::COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        step_next           = step_reg;
        step_next.kind      = kind;
        step_next.col       = x;
        step_next.has_left  = (x != '0);
        step_next.wide_left = |x[gb3s_pkg::COL_W-1:1];
        step_next.row_end   = row_end;
        step_next.pix       = {in_word.blue_in, in_word.green_in, in_word.red_in};
        if (accept)
            b_valid_next = 1'b1;
        else if (advance)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= clamp_width(gb3s_pkg::RESET_WIDTH);
            height_reg  <= clamp_height(gb3s_pkg::RESET_HEIGHT);
            col_reg     <= '0;
            row_reg     <= '0;
            drain_reg   <= '0;
            done_reg    <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    gb3s_pkg::REG_IMAGE_WIDTH:  width_reg  <= clamp_width(cfg_data);
                    gb3s_pkg::REG_IMAGE_HEIGHT: height_reg <= clamp_height(cfg_data);
                    default: ;
                endcase
            end
            col_reg     <= col_next;
            row_reg     <= row_next;
            drain_reg   <= drain_next;
            done_reg    <= done_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg <= step_next;
        end
    end

    assign rd_en   = accept & (kind != gb3s_pkg::STEP_NONE);
    assign rd_addr = x;
    assign b_valid = b_valid_reg;
    assign b_step  = step_reg;

endmodule

`default_nettype wire

FILE: src/gb3s_window.sv
// Column window and the separable 3x3 kernel that forms up to two result words.
`timescale 1ns / 1ps
`default_nettype none

module gb3s_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  gb3s_pkg::step_t      step,
    input  gb3s_pkg::pixel_t     top,
    input  gb3s_pkg::pixel_t     mid,
    input  gb3s_pkg::pixel_t     bot,
    output gb3s_pkg::out_word_t  res0,
    output gb3s_pkg::out_word_t  res1,
    output logic [1:0]           res_count
);

    typedef struct packed {
        gb3s_pkg::pixel_t top;
        gb3s_pkg::pixel_t mid;
        gb3s_pkg::pixel_t bot;
    } column_t;

    // Vertical pass of the kernel: top + 2 * middle + bottom.
    function automatic logic [gb3s_pkg::SAMPLE_W+1:0] column_sum(
        input column_t col, input int unsigned ch);
        logic [gb3s_pkg::SAMPLE_W-1:0] t;
        logic [gb3s_pkg::SAMPLE_W-1:0] m;
        logic [gb3s_pkg::SAMPLE_W-1:0] b;
        t = col.top[ch*gb3s_pkg::SAMPLE_W +: gb3s_pkg::SAMPLE_W];
        m = col.mid[ch*gb3s_pkg::SAMPLE_W +: gb3s_pkg::SAMPLE_W];
        b = col.bot[ch*gb3s_pkg::SAMPLE_W +: gb3s_pkg::SAMPLE_W];
        return (gb3s_pkg::SAMPLE_W+2)'(t) + (gb3s_pkg::SAMPLE_W+2)'({m, 1'b0})
             + (gb3s_pkg::SAMPLE_W+2)'(b);
    endfunction

    // The two columns left of the incoming one; the incoming column is the third.
    column_t prev2_reg;
    column_t prev1_reg;
    column_t cur_col;

    logic [gb3s_pkg::SAMPLE_W-1:0] val_a [gb3s_pkg::NUM_SAMPLES];
    logic [gb3s_pkg::SAMPLE_W-1:0] val_b [gb3s_pkg::NUM_SAMPLES];

    gb3s_pkg::out_word_t res_a;
    gb3s_pkg::out_word_t res_b;
    logic                emits;

    assign cur_col = '{top: top, mid: mid, bot: bot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev2_reg <= '0;
            prev1_reg <= '0;
        end
        else if (push)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= cur_col;
        end
    end

    for (genvar c = 0; c < gb3s_pkg::NUM_SAMPLES; c++)
    begin : g_chan
        logic [gb3s_pkg::SAMPLE_W+1:0] s0, s1, s2, la, lb;
        logic [gb3s_pkg::SUM_W-1:0]    total_a, total_b;

        assign s0 = column_sum(prev2_reg, c);
        assign s1 = column_sum(prev1_reg, c);
        assign s2 = column_sum(cur_col, c);

        // Pixel left of the new column; at the left border the middle column repeats.
        assign la      = step.wide_left ? s0 : s1;
        assign total_a = gb3s_pkg::SUM_W'(la) + gb3s_pkg::SUM_W'({s1, 1'b0})
                       + gb3s_pkg::SUM_W'(s2);
        // Last pixel of the row; the right border repeats the new column.
        assign lb      = step.has_left ? s1 : s2;
        assign total_b = gb3s_pkg::SUM_W'(lb) + gb3s_pkg::SUM_W'({s2, 1'b0})
                       + gb3s_pkg::SUM_W'(s2);

        assign val_a[c] = (c < gb3s_pkg::CHANNELS) ? total_a[gb3s_pkg::SUM_W-1:4] : '0;
        assign val_b[c] = (c < gb3s_pkg::CHANNELS) ? total_b[gb3s_pkg::SUM_W-1:4] : '0;
    end

    always_comb
    begin
        emits = (step.kind == gb3s_pkg::STEP_PUSH) || (step.kind == gb3s_pkg::STEP_DRAIN);

        res_a.red_out      = val_a[0];
        res_a.green_out    = val_a[1];
        res_a.blue_out     = val_a[2];
        res_a.end_of_row   = 1'b0;
        res_a.end_of_frame = 1'b0;
        res_a.last_of_step = ~step.row_end;

        res_b.red_out      = val_b[0];
        res_b.green_out    = val_b[1];
        res_b.blue_out     = val_b[2];
        res_b.end_of_row   = 1'b1;
        res_b.end_of_frame = (step.kind == gb3s_pkg::STEP_DRAIN);
        res_b.last_of_step = 1'b1;

        res0      = step.has_left ? res_a : res_b;
        res1      = res_b;
        res_count = emits ? (2'(step.has_left) + 2'(step.row_end)) : 2'd0;
    end

endmodule

`default_nettype wire

FILE: src/gb3s_ofifo.sv
// Small result queue that takes up to two words per cycle and hands out one unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module gb3s_ofifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_n,
    input  gb3s_pkg::out_word_t  d0,
    input  gb3s_pkg::out_word_t  d1,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gb3s_pkg::out_word_t  out_word,
    output logic                 room
);

    gb3s_pkg::out_word_t                mem_reg [gb3s_pkg::FIFO_DEPTH];
    logic [gb3s_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [gb3s_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [gb3s_pkg::FIFO_CNT_W-1:0]    count_reg, count_next;
    logic                               pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & ~out_stall;
    // Room for a full pair, counted without the word leaving this cycle.
    assign room      = (count_reg <= gb3s_pkg::FIFO_CNT_W'(gb3s_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + gb3s_pkg::FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + gb3s_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + gb3s_pkg::FIFO_CNT_W'(push_n)
                    - gb3s_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= d0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + gb3s_pkg::FIFO_PTR_W'(1)] <= d1;
        end
    end

endmodule

`default_nettype wire

FILE: src/gaussian_blur_3x3_stream_unit.sv
// Top level of the streaming 3x3 Gaussian blur for RGB pixels in raster order.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload          Meaning
// pixel     pixel_valid / pixel_stall  in_word_t        one pixel or one drain word
// result    result_valid / result_stall out_word_t      one blurred pixel
// config    cfg_write                  cfg_index, data  image_width, image_height
//
// A pixel word is accepted every cycle while pixel_stall is low. Its line store read is
// issued at the accepting edge, the kernel runs in the next cycle, and its results enter
// the result queue when the step register moves on. A push or drain word at the end of a
// row yields two results, or one in a one-pixel-wide image; the result port moves one
// word per cycle while result_stall is low, and the pixel side stalls while the queue
// lacks room for a pair. Reset clears the frame position, the window
// and the queue; the line stores hold no reset value and are filled by the first row.
// A configuration write restarts the frame at its first pixel and drops pending drain.
//
// Output pixel (x, y) leaves when input pixel (x+1, y+1) arrives. After the last row the
// host sends image_width drain words to flush it, with the bottom row repeated.

module gaussian_blur_3x3_stream_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gb3s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb3s_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  gb3s_pkg::in_word_t              pixel,
    output logic                            result_valid,
    input  logic                            result_stall,
    output gb3s_pkg::out_word_t             result
);

    logic                        room;
    logic                        rd_en;
    logic [gb3s_pkg::COL_W-1:0]  rd_addr;
    logic                        b_valid;
    gb3s_pkg::step_t             step;
    logic                        b_fire;

    logic                        wr_en;
    gb3s_pkg::pixel_t            older_wdata;
    gb3s_pkg::pixel_t            older_q;
    gb3s_pkg::pixel_t            newer_q;
    gb3s_pkg::pixel_t            older_rd;
    gb3s_pkg::pixel_t            newer_rd;
    gb3s_pkg::pixel_t            cur_pix;

    logic                        byp_hit_reg;
    gb3s_pkg::pixel_t            byp_older_reg;
    gb3s_pkg::pixel_t            byp_newer_reg;

    logic                        win_push;
    gb3s_pkg::out_word_t         res0;
    gb3s_pkg::out_word_t         res1;
    logic [1:0]                  res_count;
    logic [1:0]                  push_n;

    // The step register moves on whenever the queue can take a full pair.
    assign b_fire = b_valid & room;

    gb3s_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (pixel_valid),
        .in_word   (pixel),
        .advance   (room),
        .in_stall  (pixel_stall),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .b_valid   (b_valid),
        .b_step    (step)
    );

    // Both stores are written together: on the first row each takes the pixel, later the
    // newer row moves into the older store and the pixel becomes the newer row.
    assign wr_en       = b_fire & ((step.kind == gb3s_pkg::STEP_FILL) ||
                                   (step.kind == gb3s_pkg::STEP_PUSH));
    assign older_wdata = (step.kind == gb3s_pkg::STEP_FILL) ? step.pix : newer_rd;

    gb3s_ram #(
        .WIDTH (gb3s_pkg::PIXEL_W),
        .DEPTH (gb3s_pkg::MAX_WIDTH)
    ) u_older_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (step.col),
        .wdata (older_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (older_q)
    );

    gb3s_ram #(
        .WIDTH (gb3s_pkg::PIXEL_W),
        .DEPTH (gb3s_pkg::MAX_WIDTH)
    ) u_newer_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (step.col),
        .wdata (step.pix),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (newer_q)
    );

    // When a read meets the write of the word ahead at the same column (a one-pixel-wide
    // image), the RAM returns stale data, so the written values are kept and used instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_hit_reg <= wr_en & (step.col == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_older_reg <= older_wdata;
            byp_newer_reg <= step.pix;
        end
    end

    assign older_rd = byp_hit_reg ? byp_older_reg : older_q;
    assign newer_rd = byp_hit_reg ? byp_newer_reg : newer_q;

    // Drain words repeat the last row below the frame.
    assign cur_pix  = (step.kind == gb3s_pkg::STEP_DRAIN) ? newer_rd : step.pix;
    assign win_push = b_fire & ((step.kind == gb3s_pkg::STEP_PUSH) ||
                                (step.kind == gb3s_pkg::STEP_DRAIN));

    gb3s_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (win_push),
        .step      (step),
        .top       (older_rd),
        .mid       (newer_rd),
        .bot       (cur_pix),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign push_n = b_fire ? res_count : 2'd0;

    gb3s_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .d0        (res0),
        .d1        (res1),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_word  (result),
        .room      (room)
    );

    // The frame's last word always closes its row and the step that caused it.
    a_eof_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_frame |-> result.end_of_row && result.last_of_step)
        else $error("end_of_frame without end_of_row and last_of_step");

    // An accepted word always lands in the step register.
    a_accept_loads_step: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> b_valid)
        else $error("accepted word did not reach the step register");

    // The first row of a frame only fills the line stores.
    a_fill_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire && step.kind == gb3s_pkg::STEP_FILL |-> push_n == 2'd0)
        else $error("first-row pixel produced a result word");

endmodule

`default_nettype wire
